// File: rtl/core/mwbd_pkg.sv
`default_nettype none
package mwbd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_RD,
      ST_MOD,
      ST_AVG,
      ST_PUSH
   } state_type;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_BAD   = 2'd2;

   localparam logic [1:0] REG_BLOCK  = 2'd0;
   localparam logic [1:0] REG_COLS   = 2'd1;
   localparam logic [1:0] REG_ROWS   = 2'd2;
   localparam logic [1:0] REG_LIMIT  = 2'd3;

   localparam int SAMPLE_W = 32;
   localparam int SUM_W    = 48;
   localparam int WGT_W    = 15;
   localparam int POS_W    = 16;
   localparam int K_W      = 7;

endpackage
`default_nettype wire

// File: rtl/core/mwbd_if.sv
`default_nettype none
interface mwbd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample;
   logic        start_of_frame;
   modport source (output valid, output sample, output start_of_frame, input ready);
   modport sink (input valid, input sample, input start_of_frame, output ready);
endinterface

interface mwbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] average;
   logic [15:0] cell_row;
   logic [7:0]  cell_col;
   logic [1:0]  status;
   logic        last;
   modport source (output valid, output average, output cell_row, output cell_col,
                   output status, output last, input ready);
   modport sink (input valid, input average, input cell_row, input cell_col,
                 input status, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mwbd_ram.sv
`default_nettype none
module mwbd_ram #(
   parameter int WIDTH = 63,
   parameter int DEPTH = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/mwbd_div.sv
`default_nettype none
module mwbd_div #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quot,
   output logic      [DEN_W-1:0] rem
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;
endmodule
`default_nettype wire

// File: rtl/core/masked_weighted_block_downsample_top.sv
// each accepted word runs the 16-step position divide; an in-range word then updates its cell
// a cell-closing word with nonzero weight then runs the 48-step average divide before its push
// one word at a time; the next word is taken only after the last one's divides and push finish
// a finished result waits in the output register while the next word is taken
// reset: synchronous, active high; clears control, position counters and the geometry flag
// registers return to block_factor 2, fine_cols 3, fine_rows 3, valid_limit all ones
`default_nettype none
module masked_weighted_block_downsample_top #(
   parameter int MAX_COARSE_COLS = 256,
   parameter int MAX_BLOCK       = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mwbd_req_if.sink         req_chan,
   mwbd_rsp_if.source       rsp_chan,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import mwbd_pkg::*;

   localparam int ADDR_W = (MAX_COARSE_COLS > 1) ? $clog2(MAX_COARSE_COLS) : 1;
   localparam int ENT_W  = SUM_W + WGT_W;

   // configuration registers
   logic [K_W-1:0]      block_factor_ff;
   logic [14:0]         fine_cols_ff;
   logic [15:0]         fine_rows_ff;
   logic [31:0]         valid_limit_ff;
   logic                csr_wr;

   // frame position and geometry verdict
   logic [15:0]         row_cnt_ff, row_cnt_in;
   logic [14:0]         col_cnt_ff, col_cnt_in;
   logic                geo_bad_ff, geo_bad_in;

   // current word
   logic [31:0]         sample_ff;
   logic [15:0]         row_ff;
   logic [14:0]         col_ff;
   logic [15:0]         row_cur;
   logic [14:0]         col_cur;
   logic [15:0]         col_inc;
   logic [16:0]         row_inc;
   logic                req_acc;

   state_type           state_ff, state_in;

   // position dividers
   logic                pos_done, col_done, nc_done, nr_done;
   logic [15:0]         cr_q, cc_q, nc_q, nr_q;
   logic [K_W-1:0]      r_rem, c_rem, nc_rem, nr_rem;

   // decisions after the divide
   logic                first_word;
   logic                geo_fails;
   logic                in_range;
   logic                cell_done;
   logic                is_last;

   // accumulator memory
   logic [ENT_W-1:0]    ram_rdata, ram_wdata;
   logic [ADDR_W-1:0]   cell_addr;
   logic                ram_we;
   logic                open_cell;
   logic [SUM_W-1:0]    base_sum, sum_new;
   logic [WGT_W-1:0]    base_wgt, wgt_new;
   logic                smp_valid;
   logic [1:0]          wshift;
   logic                ax_r2, ax_c2;

   // average divider
   logic [WGT_W-1:0]    wgt_ff;
   logic                avg_start, avg_done;
   logic [SUM_W-1:0]    avg_q;
   logic [WGT_W-1:0]    avg_rem;

   // result staging and output register
   logic [31:0]         res_avg_ff, res_avg_in;
   logic [15:0]         res_row_ff, res_row_in;
   logic [7:0]          res_col_ff, res_col_in;
   status_type          res_st_ff, res_st_in;
   logic                res_last_ff, res_last_in;
   logic                rsp_valid_ff;
   logic [31:0]         rsp_avg_ff;
   logic [15:0]         rsp_row_ff;
   logic [7:0]          rsp_col_ff;
   status_type          rsp_st_ff;
   logic                rsp_last_ff;
   logic                rsp_load;
   logic                res_load;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_factor_ff <= K_W'(2);
         fine_cols_ff    <= 15'd3;
         fine_rows_ff    <= 16'd3;
         valid_limit_ff  <= '1;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_BLOCK: block_factor_ff <= csr_pwdata[K_W-1:0];
            REG_COLS:  fine_cols_ff    <= csr_pwdata[14:0];
            REG_ROWS:  fine_rows_ff    <= csr_pwdata[15:0];
            REG_LIMIT: valid_limit_ff  <= csr_pwdata;
            default:   ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_BLOCK: csr_prdata = {25'd0, block_factor_ff};
         REG_COLS:  csr_prdata = {17'd0, fine_cols_ff};
         REG_ROWS:  csr_prdata = {16'd0, fine_rows_ff};
         REG_LIMIT: csr_prdata = valid_limit_ff;
         default:   csr_prdata = '0;
      endcase
   end

   // ---------------- input side and position advance ----------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign row_cur        = req_chan.start_of_frame ? 16'd0 : row_cnt_ff;
   assign col_cur        = req_chan.start_of_frame ? 15'd0 : col_cnt_ff;
   assign col_inc        = {1'b0, col_cur} + 16'd1;
   assign row_inc        = {1'b0, row_cur} + 17'd1;

   always_comb begin
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      if (req_acc) begin
         // counter at or past its register wraps
         if (col_inc >= {1'b0, fine_cols_ff}) begin
            col_cnt_in = '0;
            row_cnt_in = (row_inc >= {1'b0, fine_rows_ff}) ? 16'd0 : row_inc[15:0];
         end else begin
            col_cnt_in = col_inc[14:0];
            row_cnt_in = row_cur;
         end
      end
   end

   // cell coordinates, offsets in the block and coarse grid size, all at once
   mwbd_div #(.NUM_W(POS_W), .DEN_W(K_W)) u_div_row (
      .clock (clock), .reset (reset), .start (req_acc),
      .num (row_cur), .den (block_factor_ff),
      .done (pos_done), .quot (cr_q), .rem (r_rem)
   );
   mwbd_div #(.NUM_W(POS_W), .DEN_W(K_W)) u_div_col (
      .clock (clock), .reset (reset), .start (req_acc),
      .num ({1'b0, col_cur}), .den (block_factor_ff),
      .done (col_done), .quot (cc_q), .rem (c_rem)
   );
   mwbd_div #(.NUM_W(POS_W), .DEN_W(K_W)) u_div_ncol (
      .clock (clock), .reset (reset), .start (req_acc),
      .num ({1'b0, fine_cols_ff - 15'd1}), .den (block_factor_ff),
      .done (nc_done), .quot (nc_q), .rem (nc_rem)
   );
   mwbd_div #(.NUM_W(POS_W), .DEN_W(K_W)) u_div_nrow (
      .clock (clock), .reset (reset), .start (req_acc),
      .num (fine_rows_ff - 16'd1), .den (block_factor_ff),
      .done (nr_done), .quot (nr_q), .rem (nr_rem)
   );

   // ---------------- geometry and cell decisions ----------------
   assign first_word = (row_ff == 16'd0) && (col_ff == 15'd0);
   assign geo_fails  = (block_factor_ff == '0) || (32'(block_factor_ff) > MAX_BLOCK)
                     || (fine_cols_ff < 15'd2) || (fine_rows_ff < 16'd2)
                     || (nc_rem != '0) || (nr_rem != '0)
                     || (32'(nc_q) > MAX_COARSE_COLS);
   // col below nc*k is the same as cell column below nc
   assign in_range   = (cc_q < nc_q) && (cr_q < nr_q);
   assign cell_done  = (r_rem == block_factor_ff - K_W'(1))
                     && (c_rem == block_factor_ff - K_W'(1));
   assign is_last    = (cr_q == nr_q - 16'd1) && (cc_q == nc_q - 16'd1);

   always_comb begin
      geo_bad_in = geo_bad_ff;
      if (state_ff == ST_DIV && pos_done && first_word) begin
         geo_bad_in = geo_fails;
      end
   end

   // ---------------- accumulator read-modify-write ----------------
   assign cell_addr = cc_q[ADDR_W-1:0];
   assign open_cell = (r_rem == '0) && (c_rem == '0);
   assign base_sum  = open_cell ? '0 : ram_rdata[ENT_W-1:WGT_W];
   assign base_wgt  = open_cell ? '0 : ram_rdata[WGT_W-1:0];
   assign smp_valid = sample_ff < valid_limit_ff;
   // edge of the block weighs 1 per axis, inside 2; a one-wide block counts as inside
   assign ax_r2     = (block_factor_ff == K_W'(1))
                    || !((r_rem == '0) || (r_rem == block_factor_ff - K_W'(1)));
   assign ax_c2     = (block_factor_ff == K_W'(1))
                    || !((c_rem == '0) || (c_rem == block_factor_ff - K_W'(1)));
   assign wshift    = {1'b0, ax_r2} + {1'b0, ax_c2};
   assign sum_new   = base_sum + (smp_valid ? (SUM_W'(sample_ff) << wshift) : '0);
   assign wgt_new   = base_wgt + (smp_valid ? (WGT_W'(1) << wshift) : '0);
   assign ram_wdata = {sum_new, wgt_new};

   // read issued in ST_RD, data back in ST_MOD; one word at a time so no overlap
   mwbd_ram #(.WIDTH(ENT_W), .DEPTH(MAX_COARSE_COLS)) u_acc_ram (
      .clock (clock), .wr_en (ram_we), .wr_addr (cell_addr), .wr_data (ram_wdata),
      .rd_addr (cell_addr), .rd_data (ram_rdata)
   );

   // divider loads the updated cell totals in the same cycle they are written back
   mwbd_div #(.NUM_W(SUM_W), .DEN_W(WGT_W)) u_div_avg (
      .clock (clock), .reset (reset), .start (avg_start),
      .num (sum_new), .den (wgt_new),
      .done (avg_done), .quot (avg_q), .rem (avg_rem)
   );

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (pos_done) begin
               if (first_word && geo_fails) begin
                  state_in = ST_PUSH;
               end else if (!first_word && (geo_bad_ff || geo_fails)) begin
                  state_in = ST_IDLE;
               end else if (in_range) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RD: state_in = ST_MOD;
         ST_MOD: begin
            if (!cell_done)            state_in = ST_IDLE;
            else if (wgt_new != '0)    state_in = ST_AVG;
            else                       state_in = ST_PUSH;
         end
         ST_AVG: begin
            if (avg_done) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ram_we      = 1'b0;
      avg_start   = 1'b0;
      res_load    = 1'b0;
      rsp_load    = 1'b0;
      res_avg_in  = res_avg_ff;
      res_row_in  = res_row_ff;
      res_col_in  = res_col_ff;
      res_st_in   = res_st_ff;
      res_last_in = res_last_ff;
      case (state_ff)
         ST_DIV: begin
            if (pos_done && first_word && geo_fails) begin
               res_load    = 1'b1;
               res_avg_in  = '0;
               res_row_in  = '0;
               res_col_in  = '0;
               res_st_in   = STATUS_BAD;
               res_last_in = 1'b0;
            end
         end
         ST_MOD: begin
            ram_we = 1'b1;
            if (cell_done) begin
               res_load    = 1'b1;
               res_avg_in  = '0;
               res_row_in  = cr_q;
               res_col_in  = cc_q[7:0];
               res_st_in   = (wgt_new != '0) ? STATUS_OK : STATUS_EMPTY;
               res_last_in = is_last;
               avg_start   = (wgt_new != '0);
            end
         end
         ST_AVG: begin
            if (avg_done) begin
               res_load   = 1'b1;
               res_avg_in = avg_q[31:0];
            end
         end
         ST_PUSH: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         geo_bad_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
         geo_bad_ff <= geo_bad_in;
         if (rsp_load)                    rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)         rsp_valid_ff <= 1'b0;
      end
      if (req_acc) begin
         sample_ff <= req_chan.sample;
         row_ff    <= row_cur;
         col_ff    <= col_cur;
      end
      if (ram_we) begin
         wgt_ff <= wgt_new;
      end
      if (res_load) begin
         res_avg_ff  <= res_avg_in;
         res_row_ff  <= res_row_in;
         res_col_ff  <= res_col_in;
         res_st_ff   <= res_st_in;
         res_last_ff <= res_last_in;
      end
      if (rsp_load) begin
         rsp_avg_ff  <= res_avg_ff;
         rsp_row_ff  <= res_row_ff;
         rsp_col_ff  <= res_col_ff;
         rsp_st_ff   <= res_st_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.average  = rsp_avg_ff;
   assign rsp_chan.cell_row = rsp_row_ff;
   assign rsp_chan.cell_col = rsp_col_ff;
   assign rsp_chan.status   = rsp_st_ff;
   assign rsp_chan.last     = rsp_last_ff;

   // ---------------- checks ----------------
   a_acc_to_div: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_DIV)
      else $error("accepted word did not start the position divide");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      pos_done |-> col_done && nc_done && nr_done)
      else $error("position dividers out of step");

   a_avg_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AVG |-> wgt_ff != '0)
      else $error("average divide with zero weight");

   a_avg_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AVG && avg_done |-> avg_rem < wgt_ff)
      else $error("average remainder not below the weight");

   a_nonok_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_st_ff != STATUS_OK |-> rsp_avg_ff == '0)
      else $error("average not zero on a failed cell");

   a_ram_only_mod: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> $past(state_ff) == ST_RD)
      else $error("accumulator written without a read before it");

endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
module tb_top;
   import mwbd_pkg::*;

   localparam int LIMIT_CYCLES = 3000000;
   localparam int SETTLE       = 80;    // margin for the slowest word to finish in the block
   localparam int RANDOM_WORDS = 900;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [3:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   mwbd_req_if req_chan();
   mwbd_rsp_if rsp_chan();

   masked_weighted_block_downsample_top dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // one coarse cell as it leaves the block
   typedef struct packed {
      logic [31:0] average;
      logic [15:0] cell_row;
      logic [7:0]  cell_col;
      status_type  status;
      logic        last;
   } cell_word_type;

   // cell averaging predictor plus queue of cells still owed by the block
   class cell_scoreboard;
      bit [6:0]  blk;
      bit [14:0] cols;
      bit [15:0] rows;
      bit [31:0] limit;
      bit [63:0] run_sum[256];
      bit [31:0] run_wgt[256];
      int unsigned row_at, col_at;
      bit shape_bad;
      cell_word_type owed_cells[$];
      int errors, cells_seen, words_seen, empty_seen, bad_seen;

      function new();
         blk = 2; cols = 3; rows = 3; limit = 32'hFFFF_FFFF;
         row_at = 0; col_at = 0; shape_bad = 0;
      endfunction

      function bit shape_fails();
         int unsigned kk;
         kk = blk;
         if (kk < 1 || kk > 64) return 1;
         if (cols < 2 || rows < 2) return 1;
         if (((cols - 1) % kk) != 0 || ((rows - 1) % kk) != 0) return 1;
         if ((cols - 1) / kk > 256) return 1;
         return 0;
      endfunction

      function int unsigned edge_factor(int unsigned p, int unsigned kk);
         if (kk == 1) return 2;
         return (p == 0 || p == kk - 1) ? 1 : 2;
      endfunction

      function void move_on();
         col_at++;
         if (col_at >= cols) begin
            col_at = 0;
            row_at++;
            if (row_at >= rows) row_at = 0;
         end
         col_at &= 32'h7FFF;
         row_at &= 32'hFFFF;
      endfunction

      function void note_word(bit [31:0] smp, bit sof);
         int unsigned kk, ncc, ncr, cr, cc, r, c, w;
         cell_word_type cw;
         words_seen++;
         if (sof) begin
            row_at = 0; col_at = 0;
         end
         if (row_at == 0 && col_at == 0) begin
            shape_bad = shape_fails();
            if (shape_bad) begin
               cw = '0;
               cw.status = STATUS_BAD;
               owed_cells.push_back(cw);
               bad_seen++;
               move_on();
               return;
            end
         end
         if (shape_bad || shape_fails()) begin
            move_on();
            return;
         end
         kk = blk;
         ncc = (cols - 1) / kk;
         ncr = (rows - 1) / kk;
         if (col_at < ncc * kk && row_at < ncr * kk) begin
            cr = row_at / kk; r = row_at % kk;
            cc = col_at / kk; c = col_at % kk;
            if (r == 0 && c == 0) begin
               run_sum[cc] = 0; run_wgt[cc] = 0;
            end
            if (smp < limit) begin
               w = edge_factor(r, kk) * edge_factor(c, kk);
               run_sum[cc] += 64'(smp) * 64'(w);
               run_wgt[cc] += w;
            end
            if (r == kk - 1 && c == kk - 1) begin
               cw = '0;
               if (run_wgt[cc] != 0) begin
                  cw.average = 32'(run_sum[cc] / 64'(run_wgt[cc]));
                  cw.status  = STATUS_OK;
               end else begin
                  cw.status = STATUS_EMPTY;
                  empty_seen++;
               end
               cw.cell_row = 16'(cr);
               cw.cell_col = 8'(cc);
               cw.last = (cr == ncr - 1 && cc == ncc - 1);
               owed_cells.push_back(cw);
            end
         end
         move_on();
      endfunction

      function void check_cell(cell_word_type got);
         cell_word_type exp;
         cells_seen++;
         if (owed_cells.size() == 0) begin
            $display("%0t unexpected cell: avg %h row %0d col %0d st %0d last %0d", $time,
                     got.average, got.cell_row, got.cell_col, got.status, got.last);
            errors++;
            return;
         end
         exp = owed_cells.pop_front();
         if (got !== exp) begin
            $display("%0t cell mismatch: expected avg %h row %0d col %0d st %0d last %0d",
                     $time, exp.average, exp.cell_row, exp.cell_col, exp.status, exp.last);
            $display("%0t                actual   avg %h row %0d col %0d st %0d last %0d",
                     $time, got.average, got.cell_row, got.cell_col, got.status, got.last);
            errors++;
         end
      endfunction
   endclass

   cell_scoreboard sb = new();
   int unsigned cycles = 0;
   int stall_mode = 0;
   int burst_left = 0;

   // clock and cycle limit
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // receiver: stall mode is redrawn at random periodically, mode 0 never stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (cycles % 400 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_chan.ready <= ((cycles % 9) < 4);
            default: rsp_chan.ready <= ($urandom_range(0, 40) == 0);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_cell({rsp_chan.average, rsp_chan.cell_row, rsp_chan.cell_col,
                        rsp_chan.status, rsp_chan.last});
   end

   // two-phase csr write, register lands on the access cycle edge, bus then left idle
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_BLOCK: sb.blk   = val[6:0];
         REG_COLS:  sb.cols  = val[14:0];
         REG_ROWS:  sb.rows  = val[15:0];
         default:   sb.limit = val;
      endcase
      @(posedge clock);
   endtask

   // hold off until all owed cells are out, then let the block drain
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed_cells.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_shape(int kk, int nc, int nr, logic [31:0] lim);
      wait_idle();
      csr_write(REG_BLOCK, kk);
      csr_write(REG_COLS, nc);
      csr_write(REG_ROWS, nr);
      csr_write(REG_LIMIT, lim);
   endtask

   // one word through the request channel, bursts with random gaps in between
   task automatic send_word(logic [31:0] smp, logic sof);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.sample <= smp;
      req_chan.start_of_frame <= sof;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_word(smp, sof);
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return sb.limit;
         3: return sb.limit - 1;
         default: return $urandom;
      endcase
   endfunction

   // a frame of n words, sof on the first one unless relying on the wrap
   task automatic send_frame(int n, bit sof_first, bit noisy);
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 60) == 0)
            send_word(pick_sample(), 1'b1);   // broken frame, restart
         else
            send_word(pick_sample(), (i == 0) && sof_first);
      end
   endtask

   initial begin
      int kk, ncc, ncr, nc, nr, frames, fw;
      logic [31:0] lim;
      reset = 1'b1;
      req_chan.valid = 1'b0; req_chan.sample = '0; req_chan.start_of_frame = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset shape, empty cells, bad geometry cases, extremes
      send_word(32'hFFFF_FFFF, 1'b1);
      send_frame(8, 1'b0, 1'b0);
      set_shape(1, 2, 2, 32'h0);           // every sample masked, one empty cell
      send_frame(4, 1'b1, 1'b0);
      set_shape(0, 3, 3, 32'hFFFF_FFFF);   // zero block factor
      send_frame(2, 1'b1, 1'b0);
      set_shape(65, 66, 66, 32'hFFFF_FFFF); // block factor above max
      send_frame(2, 1'b1, 1'b0);
      set_shape(2, 1, 3, 32'hFFFF_FFFF);   // too few columns
      send_frame(1, 1'b1, 1'b0);
      set_shape(2, 4, 3, 32'hFFFF_FFFF);   // columns not a multiple
      send_frame(2, 1'b1, 1'b0);
      set_shape(1, 16385, 2, 32'h8000_0000); // too many coarse columns
      send_frame(2, 1'b1, 1'b0);
      set_shape(2, 3, 65535, 32'hFFFF_FFFE); // tallest frame, partial only
      send_frame(6, 1'b1, 1'b0);

      // one wide row hitting the last coarse column, largest block over its first rows
      set_shape(1, 257, 2, $urandom);
      send_frame(257, 1'b1, 1'b0);
      set_shape(64, 65, 65, 32'hFFFF_FFFF);
      send_frame(130, 1'b1, 1'b0);

      // random phases: mostly well-formed frames, some broken shapes and restarts
      while (sb.words_seen < RANDOM_WORDS) begin
         case ($urandom_range(0, 4))
            0: kk = 1;
            1: kk = 2;
            2: kk = 3;
            default: kk = $urandom_range(1, 6);
         endcase
         ncc = $urandom_range(1, 5);
         ncr = $urandom_range(1, 3);
         nc = ncc * kk + 1;
         nr = ncr * kk + 1;
         if ($urandom_range(0, 9) == 0) nc = nc + $urandom_range(1, kk + 1);
         case ($urandom_range(0, 4))
            0: lim = 32'hFFFF_FFFF;
            1: lim = 32'h0;
            2: lim = 32'h8000_0000;
            default: lim = $urandom;
         endcase
         set_shape(kk, nc, nr, lim);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            fw = nc * nr;
            if ($urandom_range(0, 7) == 0) fw = $urandom_range(1, fw);
            send_frame(fw, (f == 0) || $urandom_range(0, 1), 1'b1);
         end
      end

      wait_idle();
      $display("run covered %0d words and %0d cells (%0d empty, %0d bad geometry)",
               sb.words_seen, sb.cells_seen, sb.empty_seen, sb.bad_seen);
      $display("block factors 0 to 65, masked and unmasked limits, broken frames");
      if (sb.errors == 0 && sb.owed_cells.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         if (sb.owed_cells.size() != 0)
            $display("%0t %0d cells never arrived", $time, sb.owed_cells.size());
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
rtl/core/mwbd_pkg.sv
rtl/core/mwbd_if.sv
rtl/core/mwbd_ram.sv
rtl/core/mwbd_div.sv
rtl/core/masked_weighted_block_downsample_top.sv
test/tb_top.sv
